>>> rtl/cfb_pkg.sv
// Shared constants and types for the channel frame builder.
package cfb_pkg;

   localparam int unsigned CFB_CHANNELS = 8;

   localparam logic [7:0] CFB_FRAME_SYNC    = 8'hAA;
   localparam logic [7:0] CFB_DEST_RESET    = 8'hFF;
   localparam logic [7:0] CFB_FUNC_RESET    = 8'hF1;

   // register indexes on the CSR port
   localparam logic CFB_REG_DEST = 1'b0;
   localparam logic CFB_REG_FUNC = 1'b1;

   // byte positions within the bytes one sample can produce
   localparam logic [3:0] CFB_STEP_SYNC  = 4'd0;
   localparam logic [3:0] CFB_STEP_DEST  = 4'd1;
   localparam logic [3:0] CFB_STEP_FUNC  = 4'd2;
   localparam logic [3:0] CFB_STEP_LEN   = 4'd3;
   localparam logic [3:0] CFB_STEP_D0    = 4'd4;
   localparam logic [3:0] CFB_STEP_D1    = 4'd5;
   localparam logic [3:0] CFB_STEP_D2    = 4'd6;
   localparam logic [3:0] CFB_STEP_D3    = 4'd7;
   localparam logic [3:0] CFB_STEP_SUM   = 4'd8;
   localparam logic [3:0] CFB_STEP_CHECK = 4'd9;

   // one sample held for serialization, with its place in the frame
   typedef struct packed {
      logic               first;
      logic               last;
      logic signed [31:0] value;
   } item_type;

endpackage

>>> rtl/cfb_frame_ctl.sv
// Channel position tracking and the sample holding register.
module cfb_frame_ctl
   import cfb_pkg::*;
#(
   parameter int unsigned CHANNELS = CFB_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_channel_value,
   input  logic               item_done,
   output logic               item_valid,
   output item_type           item
);

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   logic [IDX_W-1:0] index_ff, index_in;
   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;
   logic             accept;
   logic             is_last;

   assign req_ready = !valid_ff || item_done;
   assign accept    = req_valid && req_ready;
   assign is_last   = (index_ff == LAST_IDX);

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in      = 1'b1;
         item_in.first = (index_ff == '0);
         item_in.last  = is_last;
         item_in.value = req_channel_value;
         index_in      = is_last ? '0 : index_ff + 1'b1;
      end else if (item_done) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/cfb_byte_seq.sv
// Byte serializer with sum and add-check accumulators and output register.
module cfb_byte_seq
   import cfb_pkg::*;
#(
   parameter int unsigned CHANNELS = CFB_CHANNELS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_done,
   input  logic [7:0] dest_address,
   input  logic [7:0] function_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end
);

   localparam logic [7:0] LEN_BYTE = 8'((4 * CHANNELS) % 256);

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] run_ff, run_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;

   logic       advance, emit;
   logic [3:0] cur_step, end_step;
   logic [7:0] cur_byte, base_sum, base_run, new_sum;

   assign advance  = !out_valid_ff || rsp_ready;
   assign emit     = item_valid && advance;
   assign cur_step = busy_ff ? step_ff : (item.first ? CFB_STEP_SYNC : CFB_STEP_D0);
   assign end_step = item.last ? CFB_STEP_CHECK : CFB_STEP_D3;
   assign item_done = emit && (cur_step == end_step);

   always_comb begin
      case (cur_step)
         CFB_STEP_SYNC:  cur_byte = CFB_FRAME_SYNC;
         CFB_STEP_DEST:  cur_byte = dest_address;
         CFB_STEP_FUNC:  cur_byte = function_code;
         CFB_STEP_LEN:   cur_byte = LEN_BYTE;
         CFB_STEP_D0:    cur_byte = item.value[7:0];
         CFB_STEP_D1:    cur_byte = item.value[15:8];
         CFB_STEP_D2:    cur_byte = item.value[23:16];
         CFB_STEP_D3:    cur_byte = item.value[31:24];
         CFB_STEP_SUM:   cur_byte = sum_ff;
         CFB_STEP_CHECK: cur_byte = run_ff;
         default:        cur_byte = 8'h00;
      endcase
   end

   // a frame's checksums restart with its sync byte
   assign base_sum = (cur_step == CFB_STEP_SYNC) ? 8'h00 : sum_ff;
   assign base_run = (cur_step == CFB_STEP_SYNC) ? 8'h00 : run_ff;
   assign new_sum  = base_sum + cur_byte;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      run_in       = run_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_end_in   = (cur_step == CFB_STEP_CHECK);
         if (cur_step < CFB_STEP_SUM) begin
            sum_in = new_sum;
            run_in = base_run + new_sum;
         end
         if (cur_step == end_step) begin
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            step_in = cur_step + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      run_ff      <= run_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

>>> rtl/channel_frame_builder_dual_checksum_top.sv
// Top level of the channel frame builder: CSR block and datapath wiring.
//
//   Channel   Direction  Handshake         Payload
//   req       in         req_valid/ready   req_channel_value (32b signed sample)
//   rsp       out        rsp_valid/ready   rsp_out_byte (8b), rsp_frame_end (1b)
//   csr       in/out     APB psel/penable  paddr[2:0], pwdata/prdata (32b)
//
// Each sample leaves as 4 bytes, plus 4 header bytes on the first channel and
// 2 checksum bytes on the last, one byte per cycle while rsp is not stalled;
// the single byte output port sets this rate.
// The next sample is taken in the cycle its predecessor's last byte enters the output register.
// Reset is synchronous: it drops all queued bytes, restarts at channel 0 and
// loads dest_address 0xFF and function_code 0xF1.
// A stall on rsp holds the output register and the serializer in place.
module channel_frame_builder_dual_checksum_top
   import cfb_pkg::*;
#(
   parameter int unsigned CHANNELS = CFB_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   // sample input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_channel_value,
   // byte output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_end,
   // configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [7:0] dest_ff, dest_in;
   logic [7:0] func_ff, func_in;
   logic       csr_write;
   logic       reg_sel;
   logic       item_valid;
   logic       item_done;
   item_type   item;

   // APB: zero wait states, register index is the word address
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      dest_in = dest_ff;
      func_in = func_ff;
      if (csr_write) begin
         case (reg_sel)
            CFB_REG_DEST: dest_in = pwdata[7:0];
            CFB_REG_FUNC: func_in = pwdata[7:0];
            default:      dest_in = dest_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         CFB_REG_DEST: prdata = {24'h0, dest_ff};
         CFB_REG_FUNC: prdata = {24'h0, func_ff};
         default:      prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= CFB_DEST_RESET;
         func_ff <= CFB_FUNC_RESET;
      end else begin
         dest_ff <= dest_in;
         func_ff <= func_in;
      end
   end

   // hold one sample and tag it first/last within the frame
   cfb_frame_ctl #(
      .CHANNELS(CHANNELS)
   ) u_frame_ctl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel_value(req_channel_value),
      .item_done        (item_done),
      .item_valid       (item_valid),
      .item             (item)
   );

   // advance through header, data and checksum bytes, one beat per cycle while rsp is not stalled
   cfb_byte_seq #(
      .CHANNELS(CHANNELS)
   ) u_byte_seq (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .item_done    (item_done),
      .dest_address (dest_ff),
      .function_code(func_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the channel frame builder with dual checksums.
`timescale 1ns / 100ps

module tb_top;
   import cfb_pkg::*;

   localparam int unsigned CHANNELS       = CFB_CHANNELS;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_PHASES  = 6;
   localparam int          PHASE_SAMPLES  = 73;

   // one output beat: a frame byte and its end-of-frame flag
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   typedef enum logic [1:0] {
      ROW_SAMPLE,
      ROW_WRITE,
      ROW_READ
   } row_op_type;

   // One row of the directed table. Literal bytes are typed first byte
   // leftmost; lit_count of zero means the predictor supplies the bytes.
   typedef struct {
      row_op_type  op;
      logic        reg_idx;
      logic [31:0] value;
      int          lit_count;
      logic [79:0] lit_bytes;
      bit          lit_end;
   } stim_row_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_channel_value = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_frame_end;
   logic               psel              = 1'b0;
   logic               penable           = 1'b0;
   logic               pwrite            = 1'b0;
   logic [2:0]         paddr             = '0;
   logic [31:0]        pwdata            = '0;
   logic [31:0]        prdata;
   logic               pready;

   // predictor state: frame position, both checksums, register copies
   int          frame_chan      = 0;
   logic [7:0]  frame_sum       = '0;
   logic [7:0]  frame_add_check = '0;
   logic [7:0]  model_dest      = CFB_DEST_RESET;
   logic [7:0]  model_func      = CFB_FUNC_RESET;

   frame_beat_type frame_bytes_due[$];
   stim_row_type   directed_rows[$];
   frame_beat_type head_beat;
   int             error_count = 0;
   int             stall_left  = 0;
   int             idle_cycles = 0;
   bit             idling_on   = 1'b1;

   channel_frame_builder_dual_checksum_top #(
      .CHANNELS (CHANNELS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel_value (req_channel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_end     (rsp_frame_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_beat(input logic [7:0] data, input logic last);
      frame_beat_type beat;
      beat.data = data;
      beat.last = last;
      frame_bytes_due.push_back(beat);
   endfunction

   // Emit one frame byte; header and payload bytes feed both checksums,
   // the two trailing checksum bytes do not.
   function automatic void add_frame_byte(input logic [7:0] b, input bit counted,
                                          input logic last, input bit enqueue);
      if (enqueue)
         push_beat(b, last);
      if (counted) begin
         frame_sum       = frame_sum + b;
         frame_add_check = frame_add_check + frame_sum;
      end
   endfunction

   // Work out the bytes one accepted sample causes and advance the frame.
   // With enqueue low only the state moves (the row carries typed-in bytes).
   function automatic void build_sample_bytes(input logic [31:0] value, input bit enqueue);
      if (frame_chan == 0) begin
         frame_sum       = '0;
         frame_add_check = '0;
         add_frame_byte(CFB_FRAME_SYNC, 1'b1, 1'b0, enqueue);
         add_frame_byte(model_dest, 1'b1, 1'b0, enqueue);
         add_frame_byte(model_func, 1'b1, 1'b0, enqueue);
         add_frame_byte(8'(4 * CHANNELS), 1'b1, 1'b0, enqueue);
      end
      // little endian payload
      for (int k = 0; k < 4; k++)
         add_frame_byte(value[8*k +: 8], 1'b1, 1'b0, enqueue);
      if (frame_chan == CHANNELS - 1) begin
         add_frame_byte(frame_sum, 1'b0, 1'b0, enqueue);
         add_frame_byte(frame_add_check, 1'b0, 1'b1, enqueue);
         frame_chan      = 0;
         frame_sum       = '0;
         frame_add_check = '0;
      end else begin
         frame_chan = frame_chan + 1;
      end
   endfunction

   function automatic stim_row_type stim_row(input row_op_type op, input logic reg_idx,
                                             input logic [31:0] value, input int lit_count,
                                             input logic [79:0] lit_bytes,
                                             input bit lit_end);
      stim_row_type r;
      r.op        = op;
      r.reg_idx   = reg_idx;
      r.value     = value;
      r.lit_count = lit_count;
      r.lit_bytes = lit_bytes;
      r.lit_end   = lit_end;
      return r;
   endfunction

   // Present one sample and hold it until accepted, then log its bytes.
   // Optionally drop valid for a random burst afterwards.
   task automatic send_sample(input logic [31:0] value, input int lit_count,
                              input logic [79:0] lit_bytes, input bit lit_end);
      req_valid         <= 1'b1;
      req_channel_value <= value;
      do @(posedge clock); while (!req_ready);
      build_sample_bytes(value, lit_count == 0);
      for (int i = 0; i < lit_count; i++)
         push_beat(lit_bytes[8*(lit_count-1-i) +: 8], lit_end && (i == lit_count - 1));
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid         <= 1'b0;
         req_channel_value <= $urandom;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every byte due has left the block.
   task automatic wait_frame_drain();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; upper data bits are noise.
   task automatic csr_write(input logic idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'($urandom), val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == CFB_REG_DEST)
         model_dest = val;
      else
         model_func = val;
   endtask

   task automatic csr_read_check(input logic idx, input logic [7:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== want) begin
         $error("%s mismatch: expected %02h, actual %02h",
                (idx == CFB_REG_DEST) ? "dest_address" : "function_code",
                want, prdata[7:0]);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result side: check each accepted beat against the oldest byte due,
   // stall ready in random bursts, and run the no-progress watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_left  <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("rsp beat with no byte due: out_byte %02h frame_end %0b",
                      rsp_out_byte, rsp_frame_end);
               error_count++;
            end else begin
               head_beat = frame_bytes_due.pop_front();
               if (rsp_out_byte !== head_beat.data) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         head_beat.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_frame_end !== head_beat.last) begin
                  $error("frame_end mismatch: expected %0b, actual %0b",
                         head_beat.last, rsp_frame_end);
                  error_count++;
               end
            end
         end

         // ready held low in random bursts
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end

         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || psel) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus: reset, directed table, then random phases with new settings.
   initial begin
      // Frame at reset settings, all-zero payload: checksums are fixed.
      repeat (7)
         directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0, 0, '0, 0));
      directed_rows[0] = stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0, 8,
                                  80'hAA_FF_F1_20_00_00_00_00, 0);
      for (int i = 1; i < 7; i++)
         directed_rows[i] = stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0, 4,
                                     80'h00_00_00_00, 0);
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0, 6,
                                       80'h00_00_00_00_BA_E7, 1));
      directed_rows.push_back(stim_row(ROW_READ,  CFB_REG_DEST, 32'hFF, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_READ,  CFB_REG_FUNC, 32'hF1, 0, '0, 0));
      // Registers at zero, payload extremes.
      directed_rows.push_back(stim_row(ROW_WRITE, CFB_REG_DEST, 32'h00, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_WRITE, CFB_REG_FUNC, 32'h00, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h7FFF_FFFF, 8,
                                       80'hAA_00_00_20_FF_FF_FF_7F, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h8000_0000, 4,
                                       80'h00_00_00_80, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'hFFFF_FFFF, 4,
                                       80'hFF_FF_FF_FF, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0000_0001, 4,
                                       80'h01_00_00_00, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h1234_5678, 4,
                                       80'h78_56_34_12, 0));
      // Mid-frame write: the current frame keeps going, next header picks it up.
      directed_rows.push_back(stim_row(ROW_WRITE, CFB_REG_DEST, 32'h5A, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_WRITE, CFB_REG_FUNC, 32'hA5, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'hA5A5_A5A5, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h5A5A_5A5A, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h00FF_00FF, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'hDEAD_BEEF, 8,
                                       80'hAA_5A_A5_20_EF_BE_AD_DE, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0123_4567, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h89AB_CDEF, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'hFEDC_BA98, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h7654_3210, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h0000_0080, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h8080_8080, 0, '0, 0));
      directed_rows.push_back(stim_row(ROW_SAMPLE, CFB_REG_DEST, 32'h7F7F_7F7F, 0, '0, 0));

      // Hold reset at the start, then release it for good.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].op)
            ROW_SAMPLE: begin
               send_sample(directed_rows[i].value, directed_rows[i].lit_count,
                           directed_rows[i].lit_bytes, directed_rows[i].lit_end);
            end
            ROW_WRITE: begin
               wait_frame_drain();
               csr_write(directed_rows[i].reg_idx, directed_rows[i].value[7:0]);
            end
            ROW_READ: begin
               wait_frame_drain();
               csr_read_check(directed_rows[i].reg_idx, directed_rows[i].value[7:0]);
            end
            default: begin
            end
         endcase
      end

      // Random phases. Each starts with the sender paused until the block is
      // empty, then rewrites both registers; phase length is no multiple of
      // CHANNELS, so most writes land mid-frame. The last phase runs flat out.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_frame_drain();
         idling_on <= (phase != RANDOM_PHASES - 1);
         case (phase)
            0: begin
               csr_write(CFB_REG_DEST, 8'hFF);
               csr_write(CFB_REG_FUNC, 8'h00);
            end
            1: begin
               csr_write(CFB_REG_DEST, 8'h00);
               csr_write(CFB_REG_FUNC, 8'hFF);
            end
            default: begin
               csr_write(CFB_REG_DEST, 8'($urandom));
               csr_write(CFB_REG_FUNC, 8'($urandom));
            end
         endcase
         csr_read_check(CFB_REG_DEST, model_dest);
         csr_read_check(CFB_REG_FUNC, model_func);
         repeat (PHASE_SAMPLES) begin
            // bias toward extremes and small values, half full-range noise
            case ($urandom_range(0, 9))
               0:       send_sample(32'h0000_0000, 0, '0, 0);
               1:       send_sample(32'hFFFF_FFFF, 0, '0, 0);
               2:       send_sample(32'h8000_0000, 0, '0, 0);
               3:       send_sample(32'h7FFF_FFFF, 0, '0, 0);
               4:       send_sample(32'($urandom_range(0, 255)), 0, '0, 0);
               default: send_sample($urandom, 0, '0, 0);
            endcase
         end
      end

      // Drain everything still due, then give stray beats time to show up.
      wait_frame_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/cfb_pkg.sv
rtl/cfb_frame_ctl.sv
rtl/cfb_byte_seq.sv
rtl/channel_frame_builder_dual_checksum_top.sv
dv/tb_top.sv
